>>> hdl/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Types, constants and helper functions shared by the HTML entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

   localparam int unsigned MAX_OUT = 6;

   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;

   localparam logic [31:0] CP_MAX    = 32'h0010FFFF;
   localparam logic [31:0] CP_TWO    = 32'h00000080;
   localparam logic [31:0] CP_THREE  = 32'h00000800;
   localparam logic [31:0] CP_FOUR   = 32'h00010000;
   localparam logic [7:0]  LEAD_TWO  = 8'hC0;
   localparam logic [7:0]  LEAD_THR  = 8'hE0;
   localparam logic [7:0]  LEAD_FOUR = 8'hF0;
   localparam logic [7:0]  CONT_BYTE = 8'h80;

   localparam logic [5:0] ALL_NAMES = 6'h3F;

   // amp; lt; gt; quot; apos; nbsp;
   localparam logic [7:0] NAME_TEXT [6][5] = '{
      '{"a", "m", "p", ";", 8'h00},
      '{"l", "t", ";", 8'h00, 8'h00},
      '{"g", "t", ";", 8'h00, 8'h00},
      '{"q", "u", "o", "t", ";"},
      '{"a", "p", "o", "s", ";"},
      '{"n", "b", "s", "p", ";"}
   };
   localparam logic [2:0] NAME_LEN [6] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5, 3'd5};
   localparam logic [7:0] NAME_VAL [6] = '{"&", "<", ">", 8'h22, 8'h27, " "};

   typedef enum logic [4:0] {
      MODE_PLAIN  = 5'b00001,
      MODE_AMP    = 5'b00010,
      MODE_HASH   = 5'b00100,
      MODE_DIGITS = 5'b01000,
      MODE_NAME   = 5'b10000
   } hed_mode_type;

   typedef struct packed {
      logic [4:0][7:0] b;
      logic [2:0]      len;
   } hed_seg_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hed_digit_type;

   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] data;
      logic [2:0]              count;
      logic                    eot;
      logic                    bare;
   } hed_entry_type;

   function automatic hed_digit_type digit_of(input logic [7:0] c, input logic hex);
      hed_digit_type d;
      d = '0;
      if (c >= "0" && c <= "9") begin
         d.ok  = 1'b1;
         d.val = 4'(c - 8'h30);
      end else if (hex && c >= "a" && c <= "f") begin
         d.ok  = 1'b1;
         d.val = 4'(c - 8'h57);
      end else if (hex && c >= "A" && c <= "F") begin
         d.ok  = 1'b1;
         d.val = 4'(c - 8'h37);
      end
      return d;
   endfunction

   function automatic hed_seg_type encode_cp(input logic [31:0] cp);
      hed_seg_type s;
      s = '0;
      if (cp == 32'd0 || cp > CP_MAX) begin
         s.len = 3'd0;
      end else if (cp < CP_TWO) begin
         s.b[0] = cp[7:0];
         s.len  = 3'd1;
      end else if (cp < CP_THREE) begin
         s.b[0] = LEAD_TWO | {3'b000, cp[10:6]};
         s.b[1] = CONT_BYTE | {2'b00, cp[5:0]};
         s.len  = 3'd2;
      end else if (cp < CP_FOUR) begin
         s.b[0] = LEAD_THR | {4'h0, cp[15:12]};
         s.b[1] = CONT_BYTE | {2'b00, cp[11:6]};
         s.b[2] = CONT_BYTE | {2'b00, cp[5:0]};
         s.len  = 3'd3;
      end else begin
         s.b[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
         s.b[1] = CONT_BYTE | {2'b00, cp[17:12]};
         s.b[2] = CONT_BYTE | {2'b00, cp[11:6]};
         s.b[3] = CONT_BYTE | {2'b00, cp[5:0]};
         s.len  = 3'd4;
      end
      return s;
   endfunction

   function automatic hed_seg_type literal_ref(input logic [3:0][7:0] pend,
                                              input logic [2:0] cnt);
      hed_seg_type s;
      s      = '0;
      s.b[0] = CHAR_AMP;
      s.b[1] = pend[0];
      s.b[2] = pend[1];
      s.b[3] = pend[2];
      s.b[4] = pend[3];
      s.len  = cnt + 3'd1;
      return s;
   endfunction

endpackage

>>> hdl/html_entity_decoder.sv
// ----------------------------------------------------------------------------
// html_entity_decoder
// Streaming HTML character reference decoder producing UTF-8 bytes.
// ----------------------------------------------------------------------------
// Input channel req_*: one text byte per transaction, req_end_of_text on the
// final byte of a text. Output channel rsp_*: one byte per transaction, with
// rsp_last_in_run on the final byte caused by an input byte and rsp_text_done
// on the final byte of the text; a text end that yields no byte gives one
// transaction with rsp_byte_valid low.
// Throughput: one input byte per cycle while req_stall is low. The scanner
// turns each byte into a burst of 0 to 6 output bytes in the cycle it is
// accepted; the serializer sends one byte per cycle while rsp_stall is low.
// The first byte of a burst is written into the queue and then into the
// registered result stage before it appears on rsp_*.
// Bursts wait in a QUEUE_DEPTH-entry queue; req_stall rises when it is full,
// which happens when rsp_stall is held or long bursts arrive back to back.
// A stalled rsp_* transaction holds its payload.
// Reset (synchronous) empties the queue and the output stage and returns the
// scanner to plain text with no open reference.
// ----------------------------------------------------------------------------
module html_entity_decoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last_in_run,
   output logic       rsp_text_done
);
   import hed_pkg::*;

   logic          accept;
   logic          push;
   hed_entry_type push_entry;
   hed_entry_type head;
   logic          q_valid;
   logic          q_full;
   logic          q_pop;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   hed_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .push        (push),
      .entry       (push_entry)
   );

   hed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (q_pop),
      .head      (head),
      .not_empty (q_valid),
      .full      (q_full)
   );

   hed_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_head          (head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_in_run (rsp_last_in_run),
      .rsp_text_done   (rsp_text_done)
   );

endmodule

>>> hdl/hed_front.sv
// ----------------------------------------------------------------------------
// hed_front
// Reference scanner: classifies each input byte and builds the burst of
// output bytes it causes as one queue entry.
// ----------------------------------------------------------------------------
module hed_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  end_of_text,
   output logic                  push,
   output hed_pkg::hed_entry_type entry
);
   import hed_pkg::*;

   hed_mode_type    mode_ff, mode_nx, mode_in;
   logic [3:0][7:0] pend_ff, pend_nx;
   logic [2:0]      cnt_ff, cnt_nx, cnt_in;
   logic [31:0]     cp_ff, cp_nx, cp_in;
   logic            hex_ff, hex_nx, hex_in;
   logic [5:0]      cand_ff, cand_nx, cand_in;

   hed_digit_type   dig;
   hed_seg_type     seg_a, seg_c;
   logic            b_len;
   logic [7:0]      b_byte;
   logic            name_step, do_plain, clr;
   logic [5:0]      hit, fin, nxt;
   logic [7:0]      name_out;
   logic [31:0]     cp_mul, cp_acc;
   logic [3:0]      total;

   always_comb begin
      logic [2:0] pos;
      pos = cnt_ff;
      hit = '0;
      fin = '0;
      nxt = '0;
      name_out = 8'h00;
      for (int k = 0; k < 6; k++) begin
         hit[k] = cand_ff[k] && (pos < NAME_LEN[k]) && (NAME_TEXT[k][pos] == in_byte);
         fin[k] = hit[k] && ((pos + 3'd1) == NAME_LEN[k]);
         nxt[k] = hit[k] && !fin[k];
         if (fin[k]) begin
            name_out = NAME_VAL[k];
         end
      end
   end

   assign dig    = digit_of(in_byte, hex_ff);
   assign cp_mul = hex_ff ? (cp_ff << 4) : ((cp_ff << 3) + (cp_ff << 1));
   assign cp_acc = cp_mul + {28'h0, dig.val};

   always_comb begin
      mode_nx   = mode_ff;
      pend_nx   = pend_ff;
      cnt_nx    = cnt_ff;
      cp_nx     = cp_ff;
      hex_nx    = hex_ff;
      cand_nx   = cand_ff;
      seg_a     = '0;
      b_len     = 1'b0;
      b_byte    = in_byte;
      name_step = 1'b0;
      do_plain  = 1'b0;
      clr       = 1'b0;

      unique case (mode_ff)
         MODE_AMP: begin
            if (in_byte == CHAR_HASH) begin
               pend_nx[0] = in_byte;
               cnt_nx     = 3'd1;
               mode_nx    = MODE_HASH;
            end else begin
               name_step = 1'b1;
            end
         end
         MODE_NAME: begin
            name_step = 1'b1;
         end
         MODE_HASH: begin
            if (dig.ok) begin
               cp_nx   = {28'h0, dig.val};
               mode_nx = MODE_DIGITS;
            end else if (cnt_ff == 3'd1 && !hex_ff &&
                         (in_byte == CHAR_LOW_X || in_byte == CHAR_UP_X)) begin
               pend_nx[1] = in_byte;
               cnt_nx     = 3'd2;
               hex_nx     = 1'b1;
            end else begin
               seg_a    = literal_ref(pend_ff, cnt_ff);
               do_plain = 1'b1;
            end
         end
         MODE_DIGITS: begin
            if (dig.ok) begin
               cp_nx = cp_acc;
            end else begin
               seg_a = encode_cp(cp_ff);
               if (in_byte == CHAR_SEMI) begin
                  clr = 1'b1;
               end else begin
                  do_plain = 1'b1;
               end
            end
         end
         default: begin
            do_plain = 1'b1;
         end
      endcase

      if (name_step) begin
         if (|fin) begin
            b_len  = 1'b1;
            b_byte = name_out;
            clr    = 1'b1;
         end else if (nxt != 6'd0 && cnt_ff < 3'd4) begin
            pend_nx[cnt_ff[1:0]] = in_byte;
            cnt_nx               = cnt_ff + 3'd1;
            cand_nx              = nxt;
            mode_nx              = MODE_NAME;
         end else begin
            seg_a    = literal_ref(pend_ff, cnt_ff);
            do_plain = 1'b1;
         end
      end

      if (clr || do_plain) begin
         mode_nx = MODE_PLAIN;
         cnt_nx  = 3'd0;
         cp_nx   = 32'd0;
         hex_nx  = 1'b0;
         cand_nx = ALL_NAMES;
      end
      if (do_plain) begin
         if (in_byte == CHAR_AMP) begin
            mode_nx = MODE_AMP;
         end else begin
            b_len = 1'b1;
         end
      end
   end

   // end-of-text flush and return to idle
   always_comb begin
      seg_c   = '0;
      mode_in = mode_nx;
      cnt_in  = cnt_nx;
      cp_in   = cp_nx;
      hex_in  = hex_nx;
      cand_in = cand_nx;
      if (end_of_text) begin
         if (mode_nx == MODE_DIGITS) begin
            seg_c = encode_cp(cp_nx);
         end else if (mode_nx != MODE_PLAIN) begin
            seg_c = literal_ref(pend_nx, cnt_nx);
         end
         mode_in = MODE_PLAIN;
         cnt_in  = 3'd0;
         cp_in   = 32'd0;
         hex_in  = 1'b0;
         cand_in = ALL_NAMES;
      end
   end

   always_comb begin
      logic [3:0] len_ab;
      logic [3:0] idx;
      logic [3:0] j;
      len_ab = {1'b0, seg_a.len} + {3'b000, b_len};
      total  = len_ab + {1'b0, seg_c.len};
      entry  = '0;
      for (int i = 0; i < MAX_OUT; i++) begin
         idx = 4'(i);
         j   = idx - len_ab;
         if (idx < {1'b0, seg_a.len}) begin
            entry.data[i] = seg_a.b[idx[2:0]];
         end else if (idx < len_ab) begin
            entry.data[i] = b_byte;
         end else if (j < 4'd5) begin
            entry.data[i] = seg_c.b[j[2:0]];
         end else begin
            entry.data[i] = 8'h00;
         end
      end
      entry.bare  = (total == 4'd0);
      entry.count = entry.bare ? 3'd1 : total[2:0];
      entry.eot   = end_of_text;
   end

   assign push = accept && (total != 4'd0 || end_of_text);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         cnt_ff  <= 3'd0;
         cp_ff   <= 32'd0;
         hex_ff  <= 1'b0;
         cand_ff <= ALL_NAMES;
      end else if (accept) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         cp_ff   <= cp_in;
         hex_ff  <= hex_in;
         cand_ff <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_nx;
      end
   end

endmodule

>>> hdl/hed_queue.sv
// ----------------------------------------------------------------------------
// hed_queue
// Small FIFO of byte bursts between the scanner and the serializer.
// ----------------------------------------------------------------------------
module hed_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hed_pkg::hed_entry_type push_data,
   input  logic                  pop,
   output hed_pkg::hed_entry_type head,
   output logic                  not_empty,
   output logic                  full
);
   import hed_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   hed_entry_type store [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == FULL_CNT);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/hed_back.sv
// ----------------------------------------------------------------------------
// hed_back
// Serializer: sends the bytes of the head burst one per cycle, while
// rsp_stall is low, through a registered result stage.
// ----------------------------------------------------------------------------
module hed_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  hed_pkg::hed_entry_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_byte_valid,
   output logic                  rsp_last_in_run,
   output logic                  rsp_text_done
);
   import hed_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       vld_ff, vld_in;
   logic [7:0] byte_ff, byte_in;
   logic       bval_ff, bval_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic       out_free, load, is_last;

   assign out_free = !vld_ff || !rsp_stall;
   assign load     = out_free && q_valid;
   assign is_last  = (idx_ff == (q_head.count - 3'd1));
   assign q_pop    = load && is_last;

   always_comb begin
      idx_in  = idx_ff;
      vld_in  = vld_ff;
      byte_in = byte_ff;
      bval_in = bval_ff;
      last_in = last_ff;
      done_in = done_ff;
      if (out_free) begin
         vld_in = q_valid;
      end
      if (load) begin
         idx_in  = is_last ? 3'd0 : idx_ff + 3'd1;
         byte_in = q_head.bare ? 8'h00 : q_head.data[idx_ff];
         bval_in = !q_head.bare;
         last_in = is_last;
         done_in = is_last && q_head.eot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bval_ff <= bval_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bval_ff;
   assign rsp_last_in_run = last_ff;
   assign rsp_text_done   = done_ff;

endmodule

>>> sim/hed_checker.sv
// ----------------------------------------------------------------------------
// hed_checker
// Watches both channels of the HTML entity decoder. Each accepted input byte
// runs through a local decoder model, and the bytes it should produce are
// queued. Each accepted output transaction is compared field by field with
// the oldest queued byte. The failure count and the number of outstanding
// bytes go back to the testbench top.
// ----------------------------------------------------------------------------
module hed_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [7:0]        req_in_byte,
   input  logic              req_end_of_text,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [7:0]        rsp_out_byte,
   input  logic              rsp_byte_valid,
   input  logic              rsp_last_in_run,
   input  logic              rsp_text_done,
   output int unsigned       fail_count,
   output int unsigned       open_count
);
   import hed_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       bv;
      logic       last;
      logic       done;
   } dec_byte_type;

   localparam logic [7:0] ENT_TEXT [6][5] = '{
      '{"a", "m", "p", ";", 8'h00},
      '{"l", "t", ";", 8'h00, 8'h00},
      '{"g", "t", ";", 8'h00, 8'h00},
      '{"q", "u", "o", "t", ";"},
      '{"a", "p", "o", "s", ";"},
      '{"n", "b", "s", "p", ";"}
   };
   localparam logic [2:0] ENT_LEN [6] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5, 3'd5};
   localparam logic [7:0] ENT_VAL [6] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20};

   dec_byte_type decoded_q [$];
   int unsigned  fails;

   hed_mode_type mode;
   logic [7:0]   held [4];
   logic [2:0]   held_cnt;
   logic [31:0]  acc;
   logic         hex;
   logic [5:0]   cand;

   logic [7:0]   burst [8];
   int           burst_len;

   task automatic emit(input logic [7:0] b);
      if (burst_len < 8) begin
         burst[burst_len] = b;
         burst_len++;
      end
   endtask

   task automatic clear_ref();
      mode     = MODE_PLAIN;
      held_cnt = 3'd0;
      acc      = 32'd0;
      hex      = 1'b0;
      cand     = ALL_NAMES;
   endtask

   task automatic emit_cp(input logic [31:0] cp);
      if (cp == 32'd0 || cp > CP_MAX) begin
         // dropped
      end else if (cp < 32'h80) begin
         emit(cp[7:0]);
      end else if (cp < 32'h800) begin
         emit({3'b110, cp[10:6]});
         emit({2'b10, cp[5:0]});
      end else if (cp < 32'h10000) begin
         emit({4'b1110, cp[15:12]});
         emit({2'b10, cp[11:6]});
         emit({2'b10, cp[5:0]});
      end else begin
         emit({5'b11110, cp[20:18]});
         emit({2'b10, cp[17:12]});
         emit({2'b10, cp[11:6]});
         emit({2'b10, cp[5:0]});
      end
   endtask

   task automatic emit_literal();
      int k;
      emit(CHAR_AMP);
      for (k = 0; k < held_cnt; k++) emit(held[k]);
   endtask

   function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hx);
      logic [4:0] d;
      d = 5'd16;
      if (c >= "0" && c <= "9") d = {1'b0, 4'(c - 8'h30)};
      else if (hx && c >= "a" && c <= "f") d = {1'b0, 4'(c - 8'h57)};
      else if (hx && c >= "A" && c <= "F") d = {1'b0, 4'(c - 8'h37)};
      return d;
   endfunction

   task automatic plain_byte(input logic [7:0] c);
      clear_ref();
      if (c == CHAR_AMP) mode = MODE_AMP;
      else emit(c);
   endtask

   task automatic fail_ref(input logic [7:0] c);
      emit_literal();
      plain_byte(c);
   endtask

   task automatic name_byte(input logic [7:0] c);
      int         k;
      int         hit;
      logic [5:0] nxt;
      logic [2:0] pos;
      pos = held_cnt;
      nxt = 6'd0;
      hit = -1;
      for (k = 0; k < 6; k++) begin
         if (cand[k] && pos < ENT_LEN[k] && ENT_TEXT[k][pos] == c) begin
            if (pos + 3'd1 == ENT_LEN[k]) hit = k;
            else nxt[k] = 1'b1;
         end
      end
      if (hit >= 0) begin
         emit(ENT_VAL[hit]);
         clear_ref();
      end else if (nxt != 6'd0 && pos < 3'd4) begin
         held[pos] = c;
         held_cnt  = pos + 3'd1;
         cand      = nxt;
         mode      = MODE_NAME;
      end else begin
         fail_ref(c);
      end
   endtask

   task automatic decode(input logic [7:0] c, input logic eot);
      logic [4:0]   d;
      dec_byte_type item;
      int           k;
      burst_len = 0;
      case (mode)
         MODE_AMP: begin
            if (c == CHAR_HASH) begin
               held[0]  = c;
               held_cnt = 3'd1;
               mode     = MODE_HASH;
            end else begin
               name_byte(c);
            end
         end
         MODE_NAME: name_byte(c);
         MODE_HASH: begin
            d = digit_val(c, hex);
            if (!d[4]) begin
               acc  = {28'd0, d[3:0]};
               mode = MODE_DIGITS;
            end else if (held_cnt == 3'd1 && !hex && (c == CHAR_LOW_X || c == CHAR_UP_X)) begin
               held[1]  = c;
               held_cnt = 3'd2;
               hex      = 1'b1;
            end else begin
               fail_ref(c);
            end
         end
         MODE_DIGITS: begin
            d = digit_val(c, hex);
            if (!d[4]) begin
               acc = acc * (hex ? 32'd16 : 32'd10) + {28'd0, d[3:0]};
            end else begin
               emit_cp(acc);
               if (c == CHAR_SEMI) clear_ref();
               else plain_byte(c);
            end
         end
         default: plain_byte(c);
      endcase

      if (eot) begin
         if (mode == MODE_DIGITS) emit_cp(acc);
         else if (mode != MODE_PLAIN) emit_literal();
         clear_ref();
      end

      for (k = 0; k < burst_len; k++) begin
         item.data = burst[k];
         item.bv   = 1'b1;
         item.last = (k == burst_len - 1);
         item.done = eot && (k == burst_len - 1);
         decoded_q.push_back(item);
      end
      if (eot && burst_len == 0) begin
         item.data = 8'h00;
         item.bv   = 1'b0;
         item.last = 1'b1;
         item.done = 1'b1;
         decoded_q.push_back(item);
      end
   endtask

   task automatic check_field(input string fname, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", fname, want, got);
         fails++;
      end
   endtask

   initial begin
      fails = 0;
   end

   always @(posedge clock) begin
      dec_byte_type want;
      if (reset) begin
         clear_ref();
         held[0]  = 8'h00;
         held[1]  = 8'h00;
         held[2]  = 8'h00;
         held[3]  = 8'h00;
         decoded_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               $error("result with nothing expected: out_byte %h", rsp_out_byte);
               fails++;
            end else begin
               want = decoded_q.pop_front();
               check_field("out_byte", want.data, rsp_out_byte);
               check_field("byte_valid", {7'd0, want.bv}, {7'd0, rsp_byte_valid});
               check_field("last_in_run", {7'd0, want.last}, {7'd0, rsp_last_in_run});
               check_field("text_done", {7'd0, want.done}, {7'd0, rsp_text_done});
            end
         end
         if (req_valid && !req_stall) decode(req_in_byte, req_end_of_text);
      end
      open_count <= decoded_q.size();
      fail_count <= fails;
   end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the HTML entity decoder. Sends a short directed text set,
// then random texts made mostly of well-formed named and numeric references
// with broken references and raw bytes mixed in, across phases of sender
// idling and receiver stalling. Checking is done by hed_checker.
// ----------------------------------------------------------------------------
module tb_top;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte     = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_last_in_run;
   logic       rsp_text_done;

   int unsigned chk_fails;
   int unsigned chk_open;

   int          send_pct = 0;
   int          rcv_pct  = 0;
   int          items    = 0;
   logic [7:0]  seg_q [$];

   html_entity_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_in_run (rsp_last_in_run),
      .rsp_text_done   (rsp_text_done)
   );

   hed_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_in_run (rsp_last_in_run),
      .rsp_text_done   (rsp_text_done),
      .fail_count      (chk_fails),
      .open_count      (chk_open)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb_top NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < rcv_pct);
   end

   task automatic send_item(input logic [7:0] b, input logic eot);
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_in_byte     <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items++;
   endtask

   task automatic send_str(input string s, input logic eot_last);
      int i;
      for (i = 0; i < s.len(); i++) send_item(s[i], eot_last && (i == s.len() - 1));
   endtask

   function automatic string ent_name(input int k);
      case (k)
         0:       return "amp;";
         1:       return "lt;";
         2:       return "gt;";
         3:       return "quot;";
         4:       return "apos;";
         default: return "nbsp;";
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input int v, input logic upper);
      if (v < 10) return 8'(8'h30 + v);
      else return 8'((upper ? 8'h41 : 8'h61) + v - 10);
   endfunction

   task automatic random_segment();
      int    r;
      int    k;
      int    n;
      int    i;
      string nm;
      seg_q.delete();
      r = $urandom_range(0, 99);
      if (r < 20) begin
         seg_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 40) begin
         nm = ent_name($urandom_range(0, 5));
         seg_q.push_back("&");
         for (i = 0; i < nm.len(); i++) seg_q.push_back(nm[i]);
      end else if (r < 52) begin
         nm = ent_name($urandom_range(0, 5));
         n  = $urandom_range(0, nm.len() - 1);
         seg_q.push_back("&");
         for (i = 0; i < n; i++) seg_q.push_back(nm[i]);
         seg_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 70) begin
         seg_q.push_back("&");
         seg_q.push_back("#");
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 7);
         for (i = 0; i < n; i++) seg_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
         if ($urandom_range(0, 3) != 0) seg_q.push_back(";");
      end else if (r < 88) begin
         seg_q.push_back("&");
         seg_q.push_back("#");
         seg_q.push_back($urandom_range(0, 1) ? "x" : "X");
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
         for (i = 0; i < n; i++)
            seg_q.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
         if ($urandom_range(0, 3) != 0) seg_q.push_back(";");
      end else begin
         k = $urandom_range(0, 3);
         seg_q.push_back("&");
         case (k)
            0: begin
               seg_q.push_back("#");
               seg_q.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
               seg_q.push_back("#");
               seg_q.push_back("x");
               seg_q.push_back(8'($urandom_range(0, 255)));
            end
            2: seg_q.push_back("&");
            default: begin
               seg_q.push_back("#");
               seg_q.push_back(";");
            end
         endcase
      end
      foreach (seg_q[i]) send_item(seg_q[i], $urandom_range(0, 15) == 0);
   endtask

   initial begin
      int send_tab [4];
      int rcv_tab  [4];
      int ph;
      int start;
      int waited;
      bit drained;
      send_tab = '{0, 84, 0, 37};
      rcv_tab  = '{0, 0, 84, 37};
      drained  = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes, named ref, decimal without ';', hex surrogate
      // flushed at end, failed name, lone '&', zero code point as bare end
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_str("&lt;", 1'b0);
      send_str("&#65x", 1'b0);
      send_str("&#xd800", 1'b1);
      send_str("&q", 1'b1);
      send_str("&", 1'b1);
      send_str("&#0", 1'b1);

      for (ph = 0; ph < 4; ph++) begin
         send_pct = send_tab[ph];
         rcv_pct  = rcv_tab[ph];
         start    = items;
         while (items - start < 48) begin
            random_segment();
            if (ph == 1 && !drained && items - start >= 24) begin
               drained = 1'b1;
               req_valid <= 1'b0;
               @(posedge clock);
               while (chk_open != 0) @(posedge clock);
            end
         end
      end

      send_item("z", 1'b1);
      req_valid <= 1'b0;

      waited = 0;
      while (chk_open != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      if (chk_open != 0) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         repeat (10) @(posedge clock);
         if (chk_fails == 0 && chk_open == 0) $display("tb_top OK");
         else $display("tb_top NOT OK");
         $finish;
      end
   end

endmodule

>>> files.f
hdl/hed_pkg.sv
hdl/hed_front.sv
hdl/hed_queue.sv
hdl/hed_back.sv
hdl/html_entity_decoder.sv
sim/hed_checker.sv
sim/tb_top.sv
